>>> design/kmca_pkg.sv
// shared types, codes and default sizes for the k-means centroid accumulator
package kmca_pkg;

  localparam int DEF_MAX_POINTS  = 65536;
  localparam int DEF_COORD_WIDTH = 24;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_LOAD   = 2'd3
  } action_t;

  typedef enum logic {
    MODE_DIV  = 1'b0,
    MODE_SQRT = 1'b1
  } iter_mode_t;

  typedef struct packed {
    logic       start;
    iter_mode_t mode;
  } iter_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIVX_GO,
    ST_DIVX_RUN,
    ST_DIVY_GO,
    ST_DIVY_RUN,
    ST_DIFF_X,
    ST_MUL_X,
    ST_MUL_Y,
    ST_ADD_SQ,
    ST_ROOT_GO,
    ST_ROOT_RUN,
    ST_COMMIT
  } state_t;

endpackage

>>> design/kmca_iter_unit.sv
// shared restoring divide / square-root unit, one result bit per cycle
module kmca_iter_unit #(
  parameter int SUM_W = 41,
  parameter int CNT_W = 17,
  parameter int SQR_W = 49,
  parameter int AW    = 25
) (
  input  logic                clk,
  input  logic                rst,
  input  kmca_pkg::iter_req_t req,
  input  logic [SUM_W-1:0]    dividend,
  input  logic [CNT_W-1:0]    divisor,
  input  logic [SQR_W-1:0]    radicand,
  output logic                done,
  output logic [AW-1:0]       result
);
  import kmca_pkg::*;

  localparam int RT_W   = (SQR_W + 1) / 2;
  localparam int SRC_W  = (SUM_W > 2 * RT_W) ? SUM_W : 2 * RT_W;
  localparam int UW     = (CNT_W + 1 > AW + 3) ? CNT_W + 1 : AW + 3;
  localparam int N_MAX  = (SUM_W > RT_W) ? SUM_W : RT_W;
  localparam int STEP_W = $clog2(N_MAX + 1);

  logic              busy;
  iter_mode_t        mode;
  logic [SRC_W-1:0]  src;
  logic [UW-1:0]     rem;
  logic [AW-1:0]     acc;
  logic [CNT_W-1:0]  dvsr;
  logic [STEP_W-1:0] steps;

  logic [UW-1:0]     rem_sh;
  logic [UW-1:0]     opd;
  logic [UW:0]       diff;
  logic              ge;

  // one compare-subtract serves both recurrences
  always_comb begin
    if (mode == MODE_SQRT) begin
      rem_sh = {rem[UW-3:0], src[SRC_W-1 -: 2]};
      opd    = UW'({acc, 2'b01});
    end else begin
      rem_sh = {rem[UW-2:0], src[SRC_W-1]};
      opd    = UW'(dvsr);
    end
    diff = {1'b0, rem_sh} - {1'b0, opd};
    ge   = ~diff[UW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && steps == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mode <= req.mode;
      rem  <= '0;
      acc  <= '0;
      dvsr <= divisor;
      if (req.mode == MODE_SQRT) begin
        // radicand padded to an even width and left aligned
        src   <= SRC_W'(radicand) << (SRC_W - 2 * RT_W);
        steps <= STEP_W'(RT_W);
      end else begin
        src   <= SRC_W'(dividend) << (SRC_W - SUM_W);
        steps <= STEP_W'(SUM_W);
      end
    end else if (busy) begin
      rem   <= ge ? diff[UW-1:0] : rem_sh;
      acc   <= {acc[AW-2:0], ge};
      src   <= (mode == MODE_SQRT) ? (src << 2) : (src << 1);
      steps <= steps - 1'b1;
    end
  end

  assign result = acc;

endmodule

>>> design/kmeans_centroid_accumulator.sv
// One two-dimensional k-means cluster: point accumulation, centroid update and movement.
// Add, clear, load and an update on an empty cluster go straight to the output register and are
// accepted back to back while the output register is free. An update on a
// non-empty cluster runs on one shared bit-serial divide/square-root unit:
// two signed divisions of the SUM_W = COORD_WIDTH + clog2(MAX_POINTS+1) bit sums,
// then the squared distance through one multiplier, then a square root with a
// COORD_WIDTH+1 bit result; no new item is taken until the update is done.
// Every transfer in gives exactly one transfer out, held in an output register
// until taken, and the threshold register is written through move_threshold_we.
module kmeans_centroid_accumulator #(
  parameter int  MAX_POINTS  = kmca_pkg::DEF_MAX_POINTS,
  parameter int  COORD_WIDTH = kmca_pkg::DEF_COORD_WIDTH,
  localparam int CNT_W       = $clog2(MAX_POINTS + 1),
  localparam int MOVE_W      = COORD_WIDTH + 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          move_threshold_we,
  input  logic [MOVE_W-1:0]             move_threshold,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    action,
  input  logic signed [COORD_WIDTH-1:0] coord_x,
  input  logic signed [COORD_WIDTH-1:0] coord_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] centroid_x,
  output logic signed [COORD_WIDTH-1:0] centroid_y,
  output logic [MOVE_W-1:0]             movement,
  output logic                          below_threshold,
  output logic [CNT_W-1:0]              point_count,
  output logic                          was_empty,
  output logic                          overflow
);
  import kmca_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int SUM_W = CW + CNT_W;
  localparam int SQ_W  = 2 * CW + 1;
  localparam int SQR_W = (SQ_W > 64) ? 64 : SQ_W;

  state_t                 state, state_next;
  iter_req_t              req;
  logic                   iter_done;
  logic [MOVE_W-1:0]      iter_result;

  logic [MOVE_W-1:0]      thresh;
  logic signed [CW-1:0]   cx, cy;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic [CNT_W-1:0]       count;
  logic [MOVE_W-1:0]      last_move;

  logic signed [CW-1:0]   new_x, new_y;
  logic [CW-1:0]          dmag;
  logic [2*CW-1:0]        sqx, sqy;
  logic [SQR_W-1:0]       radicand;

  logic signed [CW-1:0]   cx_next, cy_next;
  logic signed [SUM_W-1:0] sum_x_next, sum_y_next;
  logic [CNT_W-1:0]       count_next;
  logic [MOVE_W-1:0]      move_next;
  logic                   empty_next, ovf_next;

  action_t                act;
  logic                   accept, out_free, go_update, upd_en;
  logic [SUM_W-1:0]       div_src, mag_x, mag_y;
  logic [CW-1:0]          quot, quot_neg;
  logic signed [CW-1:0]   da, db;
  logic [CW:0]            diff_ext, diff_neg;
  logic [CW-1:0]          dmag_next;
  logic [SQ_W-1:0]        sq_full;
  logic [SQR_W-1:0]       sq_sat;

  assign act       = action_t'(action);
  assign out_free  = ~out_valid | ~out_stall;
  assign in_stall  = (state != ST_IDLE) | ~out_free;
  assign accept    = in_valid & ~in_stall;
  assign go_update = (act == ACT_UPDATE) && (count != '0);
  assign upd_en    = (accept & ~go_update) | ((state == ST_COMMIT) & out_free);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req        = '{start: 1'b0, mode: MODE_DIV};
    case (state)
      ST_IDLE: begin
        if (accept && go_update) state_next = ST_DIVX_GO;
      end
      ST_DIVX_GO: begin
        req.start  = 1'b1;
        state_next = ST_DIVX_RUN;
      end
      ST_DIVX_RUN: begin
        if (iter_done) state_next = ST_DIVY_GO;
      end
      ST_DIVY_GO: begin
        req.start  = 1'b1;
        state_next = ST_DIVY_RUN;
      end
      ST_DIVY_RUN: begin
        if (iter_done) state_next = ST_DIFF_X;
      end
      ST_DIFF_X: state_next = ST_MUL_X;
      ST_MUL_X:  state_next = ST_MUL_Y;
      ST_MUL_Y:  state_next = ST_ADD_SQ;
      ST_ADD_SQ: state_next = ST_ROOT_GO;
      ST_ROOT_GO: begin
        req.start  = 1'b1;
        req.mode   = MODE_SQRT;
        state_next = ST_ROOT_RUN;
      end
      ST_ROOT_RUN: begin
        if (iter_done) state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // magnitudes of the sums; the sign is applied to the quotient afterwards
  assign mag_x   = sum_x[SUM_W-1] ? (~sum_x + 1'b1) : sum_x;
  assign mag_y   = sum_y[SUM_W-1] ? (~sum_y + 1'b1) : sum_y;
  assign div_src = (state == ST_DIVX_GO) ? mag_x : mag_y;

  kmca_iter_unit #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W),
    .SQR_W(SQR_W),
    .AW   (MOVE_W)
  ) u_iter (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .dividend(div_src),
    .divisor (count),
    .radicand(radicand),
    .done    (iter_done),
    .result  (iter_result)
  );

  assign quot     = iter_result[CW-1:0];
  assign quot_neg = ~quot + 1'b1;

  // absolute centroid shift on one axis
  assign da        = (state == ST_DIFF_X) ? new_x : new_y;
  assign db        = (state == ST_DIFF_X) ? cx : cy;
  assign diff_ext  = {da[CW-1], da} - {db[CW-1], db};
  assign diff_neg  = ~diff_ext + 1'b1;
  assign dmag_next = diff_ext[CW] ? diff_neg[CW-1:0] : diff_ext[CW-1:0];

  assign sq_full = {1'b0, sqx} + {1'b0, sqy};

  generate
    if (SQ_W > SQR_W) begin : g_sat
      assign sq_sat = (|sq_full[SQ_W-1:SQR_W]) ? '1 : sq_full[SQR_W-1:0];
    end else begin : g_nosat
      assign sq_sat = sq_full;
    end
  endgenerate

  always_ff @(posedge clk) begin
    case (state)
      ST_DIVX_RUN: if (iter_done) new_x <= sum_x[SUM_W-1] ? quot_neg : quot;
      ST_DIVY_RUN: if (iter_done) new_y <= sum_y[SUM_W-1] ? quot_neg : quot;
      ST_DIFF_X:   dmag <= dmag_next;
      ST_MUL_X: begin
        sqx  <= dmag * dmag;
        dmag <= dmag_next;
      end
      ST_MUL_Y:  sqy <= dmag * dmag;
      ST_ADD_SQ: radicand <= sq_sat;
      default: ;
    endcase
  end

  // architectural state after the current item
  always_comb begin
    cx_next    = cx;
    cy_next    = cy;
    sum_x_next = sum_x;
    sum_y_next = sum_y;
    count_next = count;
    move_next  = last_move;
    empty_next = 1'b0;
    ovf_next   = 1'b0;
    if (state == ST_COMMIT) begin
      cx_next   = new_x;
      cy_next   = new_y;
      move_next = iter_result;
    end else begin
      case (act)
        ACT_ADD: begin
          if (count < CNT_W'(MAX_POINTS)) begin
            sum_x_next = sum_x + {{CNT_W{coord_x[CW-1]}}, coord_x};
            sum_y_next = sum_y + {{CNT_W{coord_y[CW-1]}}, coord_y};
            count_next = count + 1'b1;
          end else begin
            ovf_next = 1'b1;
          end
        end
        ACT_UPDATE: begin
          // only reached here for an empty cluster
          move_next  = '0;
          empty_next = 1'b1;
        end
        ACT_CLEAR: begin
          sum_x_next = '0;
          sum_y_next = '0;
          count_next = '0;
        end
        ACT_LOAD: begin
          cx_next = coord_x;
          cy_next = coord_y;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh    <= '0;
      cx        <= '0;
      cy        <= '0;
      sum_x     <= '0;
      sum_y     <= '0;
      count     <= '0;
      last_move <= '0;
      out_valid <= 1'b0;
    end else begin
      if (move_threshold_we) thresh <= move_threshold;
      if (upd_en) begin
        cx        <= cx_next;
        cy        <= cy_next;
        sum_x     <= sum_x_next;
        sum_y     <= sum_y_next;
        count     <= count_next;
        last_move <= move_next;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (upd_en) begin
      centroid_x      <= cx_next;
      centroid_y      <= cy_next;
      movement        <= move_next;
      below_threshold <= move_next < thresh;
      point_count     <= count_next;
      was_empty       <= empty_next;
      overflow        <= ovf_next;
    end
  end

endmodule

>>> design/kmca_checker.sv
// port-level checks for the k-means centroid accumulator, bound to the top level
module kmca_checker #(
  parameter int  MAX_POINTS  = kmca_pkg::DEF_MAX_POINTS,
  parameter int  COORD_WIDTH = kmca_pkg::DEF_COORD_WIDTH,
  localparam int CNT_W       = $clog2(MAX_POINTS + 1),
  localparam int MOVE_W      = COORD_WIDTH + 1
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [COORD_WIDTH-1:0] centroid_x,
  input logic signed [COORD_WIDTH-1:0] centroid_y,
  input logic [MOVE_W-1:0]             movement,
  input logic [CNT_W-1:0]              point_count,
  input logic                          was_empty,
  input logic                          overflow
);
  import kmca_pkg::*;

  // an empty update records zero movement and is never a dropped point
  a_empty_zero_move: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_empty |-> (movement == '0) && !overflow)
    else $error("empty update with nonzero movement or overflow");

  // a point is only dropped with the count full
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> point_count == CNT_W'(MAX_POINTS))
    else $error("overflow reported below full count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> point_count <= CNT_W'(MAX_POINTS))
    else $error("point count above limit");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(centroid_x) && $stable(centroid_y)
      && $stable(movement) && $stable(point_count))
    else $error("stalled result changed");

endmodule

bind kmeans_centroid_accumulator kmca_checker #(
  .MAX_POINTS (MAX_POINTS),
  .COORD_WIDTH(COORD_WIDTH)
) u_kmca_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .centroid_x (centroid_x),
  .centroid_y (centroid_y),
  .movement   (movement),
  .point_count(point_count),
  .was_empty  (was_empty),
  .overflow   (overflow)
);

>>> tb/tb_kmeans_centroid_accumulator.sv
// self-checking testbench for the two-dimensional k-means centroid accumulator
`timescale 1ns / 100ps

module tb_kmeans_centroid_accumulator;
  import kmca_pkg::*;

  localparam int MAX_PTS     = DEF_MAX_POINTS;
  localparam int CW          = DEF_COORD_WIDTH;
  localparam int MW          = CW + 1;
  localparam int NW          = $clog2(DEF_MAX_POINTS + 1);
  localparam int QUIET_LIMIT = 5000;
  localparam int THR_TOP     = 23726567;
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};

  typedef struct {
    action_t              act;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } cluster_op_t;

  typedef struct {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic [MW-1:0]        move;
    logic                 below;
    logic [NW-1:0]        count;
    logic                 empty;
    logic                 ovf;
  } centroid_report_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 move_threshold_we = 1'b0;
  logic [MW-1:0]        move_threshold = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           action = '0;
  logic signed [CW-1:0] coord_x = '0;
  logic signed [CW-1:0] coord_y = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [CW-1:0] centroid_x;
  logic signed [CW-1:0] centroid_y;
  logic [MW-1:0]        movement;
  logic                 below_threshold;
  logic [NW-1:0]        point_count;
  logic                 was_empty;
  logic                 overflow;

  kmeans_centroid_accumulator dut (
    .clk               (clk),
    .rst               (rst),
    .move_threshold_we (move_threshold_we),
    .move_threshold    (move_threshold),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .action            (action),
    .coord_x           (coord_x),
    .coord_y           (coord_y),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .centroid_x        (centroid_x),
    .centroid_y        (centroid_y),
    .movement          (movement),
    .below_threshold   (below_threshold),
    .point_count       (point_count),
    .was_empty         (was_empty),
    .overflow          (overflow)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  cluster_op_t      op_queue[$];
  centroid_report_t report_queue[$];
  cluster_op_t      cur_op;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               fail_count = 0;
  int               ops_in = 0;
  int               reports_out = 0;
  int               moves_seen = 0;
  int               drops_seen = 0;

  // own copy of the cluster state
  logic signed [CW-1:0] cen_x = '0;
  logic signed [CW-1:0] cen_y = '0;
  longint               acc_x = 0;
  longint               acc_y = 0;
  int                   pts = 0;
  logic [MW-1:0]        last_move = '0;
  logic [MW-1:0]        thr_copy = '0;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned rem;
    longint unsigned trial;
    int              i;
    root = 0;
    rem  = 0;
    for (i = 31; i >= 0; i--) begin
      rem   = (rem << 2) | ((v >> (2 * i)) & 64'd3);
      trial = (root << 2) | 64'd1;
      root  = root << 1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = root | 64'd1;
      end
    end
    return root;
  endfunction

  task automatic apply_cluster_op(input cluster_op_t op);
    centroid_report_t r;
    longint           mx;
    longint           my;
    longint           dx;
    longint           dy;
    r.empty = 1'b0;
    r.ovf   = 1'b0;
    case (op.act)
      ACT_ADD: begin
        if (pts >= MAX_PTS) begin
          r.ovf = 1'b1;
          drops_seen++;
        end else begin
          acc_x += op.x;
          acc_y += op.y;
          pts++;
        end
      end
      ACT_UPDATE: begin
        if (pts == 0) begin
          last_move = '0;
          r.empty   = 1'b1;
        end else begin
          // signed division truncates toward zero
          mx = acc_x / longint'(pts);
          my = acc_y / longint'(pts);
          dx = mx - longint'(cen_x);
          dy = my - longint'(cen_y);
          if (dx < 0) dx = -dx;
          if (dy < 0) dy = -dy;
          last_move = MW'(int_sqrt(longint'(dx * dx + dy * dy)));
          cen_x = CW'(mx);
          cen_y = CW'(my);
          moves_seen++;
        end
      end
      ACT_CLEAR: begin
        acc_x = 0;
        acc_y = 0;
        pts   = 0;
      end
      default: begin
        cen_x = op.x;
        cen_y = op.y;
      end
    endcase
    r.cx    = cen_x;
    r.cy    = cen_y;
    r.move  = last_move;
    r.below = (last_move < thr_copy);
    r.count = NW'(pts);
    report_queue.push_back(r);
  endtask

  // driver: a new item is only taken when the previous one has transferred
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_cluster_op(cur_op);
        ops_in++;
      end
      if (!in_valid || !in_stall) begin
        if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_op = op_queue.pop_front();
          in_valid <= 1'b1;
          action   <= cur_op.act;
          coord_x  <= cur_op.x;
          coord_y  <= cur_op.y;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic cmp_field(input string fname, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    centroid_report_t want;
    if (!rst && out_valid && !out_stall) begin
      reports_out++;
      if (report_queue.size() == 0) begin
        $error("result transfer with nothing outstanding");
        fail_count++;
      end else begin
        want = report_queue.pop_front();
        cmp_field("centroid_x", want.cx, centroid_x);
        cmp_field("centroid_y", want.cy, centroid_y);
        cmp_field("movement", want.move, movement);
        cmp_field("below_threshold", want.below, below_threshold);
        cmp_field("point_count", want.count, point_count);
        cmp_field("was_empty", want.empty, was_empty);
        cmp_field("overflow", want.ovf, overflow);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic queue_op(input action_t a, input logic signed [CW-1:0] x,
                          input logic signed [CW-1:0] y);
    cluster_op_t op;
    op.act = a;
    op.x   = x;
    op.y   = y;
    op_queue.push_back(op);
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(7))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return CW'($urandom_range(64) - 32);
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (op_queue.size() != 0 || in_valid || report_queue.size() != 0);
  endtask

  // threshold is only written with nothing in flight
  task automatic start_phase(input int s_pct, input int r_pct, input logic [MW-1:0] thr);
    wait_drained();
    @(posedge clk);
    move_threshold_we <= 1'b1;
    move_threshold    <= thr;
    @(posedge clk);
    move_threshold_we <= 1'b0;
    thr_copy = thr;
    @(negedge clk);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
  endtask

  task automatic gen_random(input int n);
    int made;
    int k;
    int j;
    made = 0;
    while (made < n) begin
      if ($urandom_range(99) < 75) begin
        // an optional clear, a batch of points with occasional loads, then one or two updates
        if ($urandom_range(99) < 70) begin
          queue_op(ACT_CLEAR, rand_coord(), rand_coord());
          made++;
        end
        k = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
        for (j = 0; j < k; j++) begin
          if ($urandom_range(99) < 5) queue_op(ACT_LOAD, rand_coord(), rand_coord());
          else queue_op(ACT_ADD, rand_coord(), rand_coord());
          made++;
        end
        queue_op(ACT_UPDATE, rand_coord(), rand_coord());
        made++;
        if ($urandom_range(9) == 0) begin
          queue_op(ACT_UPDATE, rand_coord(), rand_coord());
          made++;
        end
      end else begin
        k = $urandom_range(1, 4);
        for (j = 0; j < k; j++) begin
          queue_op(action_t'($urandom_range(3)), rand_coord(), rand_coord());
          made++;
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    start_phase(18, 53, MW'(THR_TOP));
    queue_op(ACT_UPDATE, '0, '0);               // empty cluster
    queue_op(ACT_ADD, COORD_MAX, COORD_MIN);
    queue_op(ACT_ADD, COORD_MIN, COORD_MAX);
    queue_op(ACT_UPDATE, COORD_MAX, COORD_MAX); // mean of -1/2 rounds to zero
    queue_op(ACT_LOAD, COORD_MAX, COORD_MIN);
    queue_op(ACT_CLEAR, COORD_MIN, COORD_MIN);
    queue_op(ACT_ADD, COORD_MIN, COORD_MAX);
    queue_op(ACT_UPDATE, '0, '0);               // largest possible movement
    queue_op(ACT_LOAD, '0, '0);
    queue_op(ACT_CLEAR, '0, '0);
    queue_op(ACT_ADD, -CW'(3), CW'(4));
    queue_op(ACT_ADD, '0, CW'(1));
    queue_op(ACT_UPDATE, '0, '0);
    queue_op(ACT_UPDATE, '0, '0);               // no movement on a repeat
    queue_op(ACT_ADD, '1, '1);
    queue_op(ACT_ADD, CW'(24'h555555), CW'(24'haaaaaa));
    queue_op(ACT_ADD, CW'(24'haaaaaa), CW'(24'h555555));
    queue_op(ACT_UPDATE, '1, '1);
    queue_op(ACT_CLEAR, '1, '1);
    queue_op(ACT_LOAD, COORD_MIN, COORD_MAX);
    queue_op(ACT_UPDATE, '0, '0);               // empty after clear keeps the centroid
    gen_random(630);

    start_phase(53, 18, '0);
    gen_random(630);

    start_phase(0, 0, MW'($urandom_range(THR_TOP)));
    gen_random(640);

    // short tail at full rate around a fresh clear
    start_phase(0, 0, MW'($urandom_range(THR_TOP)));
    queue_op(ACT_CLEAR, '0, '0);
    queue_op(ACT_ADD, COORD_MIN, COORD_MAX);
    queue_op(ACT_ADD, rand_coord(), rand_coord());
    queue_op(ACT_ADD, COORD_MAX, COORD_MIN);
    queue_op(ACT_UPDATE, '0, '0);
    queue_op(ACT_ADD, rand_coord(), rand_coord());
    queue_op(ACT_LOAD, COORD_MAX, COORD_MIN);
    queue_op(ACT_UPDATE, '0, '0);
    queue_op(ACT_CLEAR, '0, '0);
    queue_op(ACT_ADD, rand_coord(), rand_coord());
    queue_op(ACT_UPDATE, '0, '0);

    wait_drained();
    repeat (150) @(posedge clk);
    $display("run covered %0d operations and %0d reported results", ops_in, reports_out);
    $display("including %0d centroid moves and %0d dropped points at a full cluster",
             moves_seen, drops_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
